FILE: sv/wsba_pkg.sv
// Shared types and constants for the weighted spectrum beam accumulator.
// Used by wsba_ctrl, wsba_datapath and the top level.
package wsba_pkg;

    localparam int BINS_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int BIN_W    = 6;
    localparam int SCAN_W   = 16;
    localparam int SEC_W    = 31;
    localparam int NS_W     = 30;
    localparam int OFFS_W   = 32;
    localparam int FFTS_W   = 11;
    localparam int WNS_W    = 30;
    localparam int NBIN_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_FFTS_PER_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE     = 2'd2;

    localparam logic [FFTS_W-1:0] FFTS_RESET = 11'd1;
    localparam logic [FFTS_W-1:0] FFTS_MAX   = 11'd1024;
    localparam logic [FFTS_W-1:0] FFT_CNT_MAX = 11'd2047;
    localparam logic [WNS_W-1:0]  WNS_RESET  = 30'd1000000;
    localparam logic [WNS_W-1:0]  WNS_MAX    = 30'd999999999;
    localparam logic [NBIN_W-1:0] NBIN_RESET = 7'd64;

    localparam logic [NS_W:0] NS_PER_SEC   = 31'd1000000000;
    localparam logic [NS_W:0] NS_PER_2SEC  = 31'd2000000000;

    typedef struct packed {
        logic load;       // capture input transaction, read its bin
        logic mul;        // register weighted products
        logic acc;        // saturating add, write back, close check
        logic emit_rd;    // read bin at emission counter
        logic emit_next;  // advance emission counter
        logic emit_done;  // window delivered: clear store, rewind counter
    } wsba_cmd_t;

    typedef struct packed {
        logic close;      // current item closes the window
        logic emit_last;  // emission counter at final bin
    } wsba_stat_t;

endpackage

FILE: sv/weighted_spectrum_beam_accumulator_core.sv
// Weighted spectrum beam accumulator, top level: configuration registers,
// controller and datapath. Depends on wsba_pkg, wsba_ctrl, wsba_datapath.
//
// Usage:
//   s_* channel: one complex spectral sample with its weight, bin, FFT and
//   subint flags and subint tag per transaction. m_* channel: one transaction
//   per emitted bin, bins 0..bins_in_use-1 in order (count clamped to 1..BINS),
//   m_last on the final one. cfg_* channel: register writes (index, data),
//   always ready; write only while the block is idle.
// Sequencing:
//   A sample passes through capture and store read, multiply, then saturating
//   add and write back; s_ready stays low until the bin is written back.
//   A window close then emits each bin by a store read and then the output,
//   which waits for m_ready; s_ready stays low for the whole burst and the
//   output payload holds while stalled.
// Reset: aresetn synchronous active low. Registers return to their defaults,
//   the bin store reads as zero (per-bin valid bits, cleared at once), the
//   FFT count and window offsets clear. No clearing pass is needed.
module weighted_spectrum_beam_accumulator_core #(
    parameter int BINS = wsba_pkg::BINS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [wsba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [wsba_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [wsba_pkg::SAMPLE_W-1:0]   s_sample_re,
    input  logic signed [wsba_pkg::SAMPLE_W-1:0]   s_sample_im,
    input  logic signed [wsba_pkg::SAMPLE_W-1:0]   s_weight,
    input  logic        [wsba_pkg::BIN_W-1:0]      s_bin,
    input  logic                                   s_end_of_fft,
    input  logic                                   s_end_of_subint,
    input  logic        [wsba_pkg::SCAN_W-1:0]     s_scan,
    input  logic        [wsba_pkg::SEC_W-1:0]      s_subint_sec,
    input  logic        [wsba_pkg::NS_W-1:0]       s_subint_ns,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [wsba_pkg::SCAN_W-1:0]     m_out_scan,
    output logic        [wsba_pkg::SEC_W-1:0]      m_out_sec,
    output logic        [wsba_pkg::NS_W-1:0]       m_out_ns,
    output logic        [wsba_pkg::BIN_W-1:0]      m_out_bin,
    output logic signed [wsba_pkg::ACC_W-1:0]      m_out_re,
    output logic signed [wsba_pkg::ACC_W-1:0]      m_out_im,
    output logic                                   m_last
);

    logic [wsba_pkg::FFTS_W-1:0] ffts_reg;
    logic [wsba_pkg::WNS_W-1:0]  wns_reg;
    logic [wsba_pkg::NBIN_W-1:0] nbin_reg;

    wsba_pkg::wsba_cmd_t  cmd;
    wsba_pkg::wsba_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ffts_reg <= wsba_pkg::FFTS_RESET;
            wns_reg  <= wsba_pkg::WNS_RESET;
            nbin_reg <= wsba_pkg::NBIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wsba_pkg::CFG_FFTS_PER_WINDOW: ffts_reg <= cfg_data[wsba_pkg::FFTS_W-1:0];
                wsba_pkg::CFG_WINDOW_NS:       wns_reg  <= cfg_data[wsba_pkg::WNS_W-1:0];
                wsba_pkg::CFG_BINS_IN_USE:     nbin_reg <= cfg_data[wsba_pkg::NBIN_W-1:0];
                default: ;
            endcase
        end
    end

    wsba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wsba_datapath #(
        .BINS (BINS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .ffts_per_window (ffts_reg),
        .window_ns       (wns_reg),
        .bins_in_use     (nbin_reg),
        .sample_re       (s_sample_re),
        .sample_im       (s_sample_im),
        .weight          (s_weight),
        .bin             (s_bin),
        .end_of_fft      (s_end_of_fft),
        .end_of_subint   (s_end_of_subint),
        .scan            (s_scan),
        .subint_sec      (s_subint_sec),
        .subint_ns       (s_subint_ns),
        .out_scan        (m_out_scan),
        .out_sec         (m_out_sec),
        .out_ns          (m_out_ns),
        .out_bin         (m_out_bin),
        .out_re          (m_out_re),
        .out_im          (m_out_im),
        .last            (m_last)
    );

endmodule

FILE: sv/wsba_ctrl.sv
// Controller FSM for the beam accumulator: sequences accumulate and emission.
// Depends on wsba_pkg for the command and status structs.
module wsba_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  wsba_pkg::wsba_stat_t stat,
    output wsba_pkg::wsba_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RD,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load     = 1'b1;
                    s_ready_next = 1'b0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (stat.close) begin
                    state_next = ST_RD;
                end else begin
                    s_ready_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.emit_rd  = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (stat.emit_last) begin
                        cmd.emit_done = 1'b1;
                        s_ready_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/wsba_datapath.sv
// Datapath for the beam accumulator: bin store, multiply, saturating add,
// FFT counting and window timestamps. Depends on wsba_pkg.
module wsba_datapath #(
    parameter int BINS = wsba_pkg::BINS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wsba_pkg::wsba_cmd_t                  cmd,
    output wsba_pkg::wsba_stat_t                 stat,
    // configuration
    input  logic        [wsba_pkg::FFTS_W-1:0]   ffts_per_window,
    input  logic        [wsba_pkg::WNS_W-1:0]    window_ns,
    input  logic        [wsba_pkg::NBIN_W-1:0]   bins_in_use,
    // input payload
    input  logic signed [wsba_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [wsba_pkg::SAMPLE_W-1:0] sample_im,
    input  logic signed [wsba_pkg::SAMPLE_W-1:0] weight,
    input  logic        [wsba_pkg::BIN_W-1:0]    bin,
    input  logic                                 end_of_fft,
    input  logic                                 end_of_subint,
    input  logic        [wsba_pkg::SCAN_W-1:0]   scan,
    input  logic        [wsba_pkg::SEC_W-1:0]    subint_sec,
    input  logic        [wsba_pkg::NS_W-1:0]     subint_ns,
    // result payload
    output logic        [wsba_pkg::SCAN_W-1:0]   out_scan,
    output logic        [wsba_pkg::SEC_W-1:0]    out_sec,
    output logic        [wsba_pkg::NS_W-1:0]     out_ns,
    output logic        [wsba_pkg::BIN_W-1:0]    out_bin,
    output logic signed [wsba_pkg::ACC_W-1:0]    out_re,
    output logic signed [wsba_pkg::ACC_W-1:0]    out_im,
    output logic                                 last
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [wsba_pkg::NBIN_W-1:0] BINS_N = wsba_pkg::NBIN_W'(BINS);

    localparam int ACC_W  = wsba_pkg::ACC_W;
    localparam int PROD_W = wsba_pkg::PROD_W;
    localparam int NS_W   = wsba_pkg::NS_W;
    localparam int SEC_W  = wsba_pkg::SEC_W;

    // accumulator store; valid bits stand in for the cleared state
    logic signed [ACC_W-1:0] mem_re [BINS];
    logic signed [ACC_W-1:0] mem_im [BINS];
    logic [BINS-1:0]         vld_reg;

    logic signed [ACC_W-1:0]  rd_re_reg, rd_im_reg;
    logic                     rd_vld_reg;
    logic [AW-1:0]            rd_addr;

    // captured item
    logic signed [wsba_pkg::SAMPLE_W-1:0] re_reg, im_reg, w_reg;
    logic [wsba_pkg::BIN_W-1:0]  bin_reg;
    logic                        eof_reg, eos_reg;
    logic [wsba_pkg::SCAN_W-1:0] scan_reg;
    logic [SEC_W-1:0]            ssec_reg;
    logic [NS_W-1:0]             sns_reg;

    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;

    logic [wsba_pkg::FFTS_W-1:0] fft_cnt_reg, fft_cnt_next;
    logic [NS_W-1:0]             off_ns_reg, off_ns_next;
    logic [wsba_pkg::OFFS_W-1:0] off_sec_reg, off_sec_next;

    logic [NS_W:0]  tns_reg;
    logic [NS_W-1:0]  tout_ns_reg;
    logic [SEC_W-1:0] tout_sec_reg;

    logic [AW-1:0] k_reg;

    // accumulate path
    logic signed [ACC_W-1:0] old_re, old_im, new_re, new_im;
    logic                    bin_ok;
    logic [wsba_pkg::FFTS_W-1:0] limit, cnt_inc;
    logic close_now;
    logic [wsba_pkg::WNS_W-1:0]  wns;
    logic [NS_W:0]               off_sum;
    logic [1:0]                  q;
    logic [NS_W:0]               q_ns;
    logic [wsba_pkg::NBIN_W-1:0] nb;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    assign rd_addr = cmd.load ? bin[AW-1:0] : k_reg;

    always_comb begin
        old_re = rd_vld_reg ? rd_re_reg : '0;
        old_im = rd_vld_reg ? rd_im_reg : '0;
        new_re = sat_add(old_re, prod_re_reg);
        new_im = sat_add(old_im, prod_im_reg);
    end

    assign bin_ok = ({1'b0, bin_reg} < (wsba_pkg::BIN_W+1)'(BINS));

    // close decision
    always_comb begin
        if (ffts_per_window == '0) begin
            limit = wsba_pkg::FFTS_W'(1);
        end else if (ffts_per_window > wsba_pkg::FFTS_MAX) begin
            limit = wsba_pkg::FFTS_MAX;
        end else begin
            limit = ffts_per_window;
        end
        cnt_inc = (fft_cnt_reg < wsba_pkg::FFT_CNT_MAX) ? fft_cnt_reg + 1'b1 : fft_cnt_reg;
        close_now = eos_reg || (eof_reg && (cnt_inc >= limit));
    end

    // window offset advance
    always_comb begin
        if (window_ns == '0) begin
            wns = wsba_pkg::WNS_W'(1);
        end else if (window_ns > wsba_pkg::WNS_MAX) begin
            wns = wsba_pkg::WNS_MAX;
        end else begin
            wns = window_ns;
        end
        off_sum = {1'b0, off_ns_reg} + {1'b0, wns};
        fft_cnt_next = fft_cnt_reg;
        off_ns_next  = off_ns_reg;
        off_sec_next = off_sec_reg;
        if (cmd.acc) begin
            if (eof_reg) begin
                fft_cnt_next = cnt_inc;
            end
            if (close_now) begin
                fft_cnt_next = '0;
                if (eos_reg) begin
                    off_ns_next  = '0;
                    off_sec_next = '0;
                end else if (off_sum >= wsba_pkg::NS_PER_SEC) begin
                    off_ns_next  = NS_W'(off_sum - wsba_pkg::NS_PER_SEC);
                    off_sec_next = off_sec_reg + 1'b1;
                end else begin
                    off_ns_next  = off_sum[NS_W-1:0];
                end
            end
        end
    end

    // window start: subint ns plus offset is below three seconds
    always_comb begin
        if (tns_reg >= wsba_pkg::NS_PER_2SEC) begin
            q    = 2'd2;
            q_ns = wsba_pkg::NS_PER_2SEC;
        end else if (tns_reg >= wsba_pkg::NS_PER_SEC) begin
            q    = 2'd1;
            q_ns = wsba_pkg::NS_PER_SEC;
        end else begin
            q    = 2'd0;
            q_ns = '0;
        end
    end

    always_comb begin
        if (bins_in_use == '0) begin
            nb = wsba_pkg::NBIN_W'(1);
        end else if (bins_in_use > BINS_N) begin
            nb = BINS_N;
        end else begin
            nb = bins_in_use;
        end
    end

    assign stat.close     = close_now;
    assign stat.emit_last = (wsba_pkg::NBIN_W'(k_reg) == nb - 1'b1);

    // store: one read port, one write port
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.emit_rd) begin
            rd_re_reg <= mem_re[rd_addr];
            rd_im_reg <= mem_im[rd_addr];
        end
        if (cmd.acc && bin_ok) begin
            mem_re[bin_reg[AW-1:0]] <= new_re;
            mem_im[bin_reg[AW-1:0]] <= new_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fft_cnt_reg <= '0;
            off_ns_reg  <= '0;
            off_sec_reg <= '0;
            k_reg       <= '0;
        end else begin
            if (cmd.load || cmd.emit_rd) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (cmd.emit_done) begin
                vld_reg <= '0;
            end else if (cmd.acc && bin_ok) begin
                vld_reg[bin_reg[AW-1:0]] <= 1'b1;
            end
            fft_cnt_reg <= fft_cnt_next;
            off_ns_reg  <= off_ns_next;
            off_sec_reg <= off_sec_next;
            if (cmd.emit_done) begin
                k_reg <= '0;
            end else if (cmd.emit_next) begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            re_reg   <= sample_re;
            im_reg   <= sample_im;
            w_reg    <= weight;
            bin_reg  <= bin;
            eof_reg  <= end_of_fft;
            eos_reg  <= end_of_subint;
            scan_reg <= scan;
            ssec_reg <= subint_sec;
            sns_reg  <= subint_ns;
        end
        if (cmd.mul) begin
            prod_re_reg <= re_reg * w_reg;
            prod_im_reg <= im_reg * w_reg;
            tns_reg     <= {1'b0, sns_reg} + {1'b0, off_ns_reg};
        end
        if (cmd.acc) begin
            tout_ns_reg  <= NS_W'(tns_reg - q_ns);
            tout_sec_reg <= ssec_reg + off_sec_reg[SEC_W-1:0] + SEC_W'(q);
        end
    end

    assign out_scan = scan_reg;
    assign out_sec  = tout_sec_reg;
    assign out_ns   = tout_ns_reg;
    assign out_bin  = wsba_pkg::BIN_W'(k_reg);
    assign out_re   = rd_vld_reg ? rd_re_reg : '0;
    assign out_im   = rd_vld_reg ? rd_im_reg : '0;
    assign last     = stat.emit_last;

endmodule

FILE: bench/wsba_window_tracker_pkg.sv
// Transaction types and the window tracker class for the beam accumulator bench.
// The tracker predicts every emitted bin and checks DUT output against it.
// Depends on wsba_pkg.
package wsba_window_tracker_pkg;

    localparam int              TRK_BINS  = wsba_pkg::BINS_DEF;
    localparam longint          ACC_HI    = 64'sd140737488355327;
    localparam longint          ACC_LO    = -64'sd140737488355328;
    localparam longint unsigned NS_IN_SEC = 64'd1000000000;

    typedef struct {
        logic signed [wsba_pkg::SAMPLE_W-1:0] re;
        logic signed [wsba_pkg::SAMPLE_W-1:0] im;
        logic signed [wsba_pkg::SAMPLE_W-1:0] weight;
        logic        [wsba_pkg::BIN_W-1:0]    bin;
        logic                                 eof;
        logic                                 eos;
        logic        [wsba_pkg::SCAN_W-1:0]   scan;
        logic        [wsba_pkg::SEC_W-1:0]    sec;
        logic        [wsba_pkg::NS_W-1:0]     ns;
    } spectral_sample_t;

    typedef struct {
        logic        [wsba_pkg::SCAN_W-1:0] scan;
        logic        [wsba_pkg::SEC_W-1:0]  sec;
        logic        [wsba_pkg::NS_W-1:0]   ns;
        logic        [wsba_pkg::BIN_W-1:0]  bin;
        logic signed [wsba_pkg::ACC_W-1:0]  re;
        logic signed [wsba_pkg::ACC_W-1:0]  im;
        logic                               last;
    } bin_record_t;

    class window_tracker;
        logic [wsba_pkg::FFTS_W-1:0] ffts_reg;
        logic [wsba_pkg::WNS_W-1:0]  wns_reg;
        logic [wsba_pkg::NBIN_W-1:0] nbins_reg;
        longint                      acc_re[TRK_BINS];
        longint                      acc_im[TRK_BINS];
        int unsigned                 fft_cnt;
        longint unsigned             offs_ns;
        longint unsigned             offs_sec;
        bin_record_t                 due_bins[$];
        int                          errors;

        function new();
            ffts_reg  = wsba_pkg::FFTS_RESET;
            wns_reg   = wsba_pkg::WNS_RESET;
            nbins_reg = wsba_pkg::NBIN_RESET;
            clear_store();
            fft_cnt  = 0;
            offs_ns  = 0;
            offs_sec = 0;
            errors   = 0;
        endfunction

        function void clear_store();
            foreach (acc_re[i]) begin
                acc_re[i] = 0;
                acc_im[i] = 0;
            end
        endfunction

        function void write_reg(logic [wsba_pkg::CFG_IDX_W-1:0] idx,
                                logic [wsba_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wsba_pkg::CFG_FFTS_PER_WINDOW: ffts_reg  = data[wsba_pkg::FFTS_W-1:0];
                wsba_pkg::CFG_WINDOW_NS:       wns_reg   = data[wsba_pkg::WNS_W-1:0];
                wsba_pkg::CFG_BINS_IN_USE:     nbins_reg = data[wsba_pkg::NBIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned ffts_used();
            if (ffts_reg == 0) return 1;
            if (ffts_reg > wsba_pkg::FFTS_MAX) return wsba_pkg::FFTS_MAX;
            return ffts_reg;
        endfunction

        function longint unsigned wns_used();
            if (wns_reg == 0) return 1;
            if (wns_reg > wsba_pkg::WNS_MAX) return wsba_pkg::WNS_MAX;
            return wns_reg;
        endfunction

        function int bins_used();
            if (nbins_reg == 0) return 1;
            if (nbins_reg > TRK_BINS) return TRK_BINS;
            return int'(nbins_reg);
        endfunction

        function longint sat48(longint v);
            if (v > ACC_HI) return ACC_HI;
            if (v < ACC_LO) return ACC_LO;
            return v;
        endfunction

        function int pending();
            return due_bins.size();
        endfunction

        // one accepted sample: accumulate, then emit the window if it closes
        function void take_sample(spectral_sample_t s);
            longint          p_re;
            longint          p_im;
            longint unsigned tns;
            longint unsigned tsec;
            int              nb;
            bit              close;
            bin_record_t     r;
            p_re = longint'(s.re) * longint'(s.weight);
            p_im = longint'(s.im) * longint'(s.weight);
            acc_re[s.bin] = sat48(acc_re[s.bin] + p_re);
            acc_im[s.bin] = sat48(acc_im[s.bin] + p_im);
            close = s.eos;
            if (s.eof) begin
                if (fft_cnt < wsba_pkg::FFT_CNT_MAX) fft_cnt++;
                if (fft_cnt >= ffts_used()) close = 1'b1;
            end
            if (close) begin
                tns  = s.ns;
                tns  = tns + offs_ns;
                tsec = s.sec;
                tsec = tsec + offs_sec + tns / NS_IN_SEC;
                tns  = tns % NS_IN_SEC;
                nb   = bins_used();
                for (int k = 0; k < nb; k++) begin
                    r.scan = s.scan;
                    r.sec  = tsec[wsba_pkg::SEC_W-1:0];
                    r.ns   = tns[wsba_pkg::NS_W-1:0];
                    r.bin  = k[wsba_pkg::BIN_W-1:0];
                    r.re   = acc_re[k][wsba_pkg::ACC_W-1:0];
                    r.im   = acc_im[k][wsba_pkg::ACC_W-1:0];
                    r.last = (k == nb - 1);
                    due_bins.insert(due_bins.size(), r);
                end
                clear_store();
                fft_cnt = 0;
                if (s.eos) begin
                    offs_ns  = 0;
                    offs_sec = 0;
                end else begin
                    offs_ns = offs_ns + wns_used();
                    if (offs_ns >= NS_IN_SEC) begin
                        offs_ns  = offs_ns - NS_IN_SEC;
                        offs_sec = (offs_sec + 1) & 64'hFFFF_FFFF;
                    end
                end
            end
        endfunction

        function void field_ok(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_bin(bin_record_t got);
            bin_record_t want;
            if (due_bins.size() == 0) begin
                $error("bin %0d emitted with no window pending", got.bin);
                errors++;
                return;
            end
            want = due_bins.pop_front();
            field_ok("out_scan", want.scan, got.scan);
            field_ok("out_sec", want.sec, got.sec);
            field_ok("out_ns", want.ns, got.ns);
            field_ok("out_bin", want.bin, got.bin);
            field_ok("out_re", want.re, got.re);
            field_ok("out_im", want.im, got.im);
            field_ok("last", want.last, got.last);
        endfunction
    endclass

endpackage

FILE: bench/tb_weighted_spectrum_beam_accumulator_core.sv
// Testbench top for weighted_spectrum_beam_accumulator_core: directed, full-scale
// and random windowed traffic with random stalls. Depends on wsba_pkg,
// wsba_window_tracker_pkg and the DUT.
module tb_weighted_spectrum_beam_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int          SAT_ITEMS   = 16;
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_ITEMS = 50;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic        [wsba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [wsba_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                                   s_valid         = 1'b0;
    logic                                   s_ready;
    logic signed [wsba_pkg::SAMPLE_W-1:0]   s_sample_re     = '0;
    logic signed [wsba_pkg::SAMPLE_W-1:0]   s_sample_im     = '0;
    logic signed [wsba_pkg::SAMPLE_W-1:0]   s_weight        = '0;
    logic        [wsba_pkg::BIN_W-1:0]      s_bin           = '0;
    logic                                   s_end_of_fft    = 1'b0;
    logic                                   s_end_of_subint = 1'b0;
    logic        [wsba_pkg::SCAN_W-1:0]     s_scan          = '0;
    logic        [wsba_pkg::SEC_W-1:0]      s_subint_sec    = '0;
    logic        [wsba_pkg::NS_W-1:0]       s_subint_ns     = '0;

    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic        [wsba_pkg::SCAN_W-1:0]     m_out_scan;
    logic        [wsba_pkg::SEC_W-1:0]      m_out_sec;
    logic        [wsba_pkg::NS_W-1:0]       m_out_ns;
    logic        [wsba_pkg::BIN_W-1:0]      m_out_bin;
    logic signed [wsba_pkg::ACC_W-1:0]      m_out_re;
    logic signed [wsba_pkg::ACC_W-1:0]      m_out_im;
    logic                                   m_last;

    bit                                        s_gaps = 1'b1;
    bit                                        m_gaps = 1'b1;
    int unsigned                               cycles = 0;
    wsba_window_tracker_pkg::window_tracker    tracker;
    wsba_window_tracker_pkg::spectral_sample_t seen_in;
    wsba_window_tracker_pkg::bin_record_t      seen_out;

    weighted_spectrum_beam_accumulator_core dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_weighted_spectrum_beam_accumulator_core: FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= !m_gaps || ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                seen_out.scan = m_out_scan;
                seen_out.sec  = m_out_sec;
                seen_out.ns   = m_out_ns;
                seen_out.bin  = m_out_bin;
                seen_out.re   = m_out_re;
                seen_out.im   = m_out_im;
                seen_out.last = m_last;
                tracker.check_bin(seen_out);
            end
            if (s_valid && s_ready) begin
                seen_in.re     = s_sample_re;
                seen_in.im     = s_sample_im;
                seen_in.weight = s_weight;
                seen_in.bin    = s_bin;
                seen_in.eof    = s_end_of_fft;
                seen_in.eos    = s_end_of_subint;
                seen_in.scan   = s_scan;
                seen_in.sec    = s_subint_sec;
                seen_in.ns     = s_subint_ns;
                tracker.take_sample(seen_in);
            end
        end
    end

    function automatic wsba_window_tracker_pkg::spectral_sample_t sample_of(
        logic signed [wsba_pkg::SAMPLE_W-1:0] re,
        logic signed [wsba_pkg::SAMPLE_W-1:0] im,
        logic signed [wsba_pkg::SAMPLE_W-1:0] weight,
        logic        [wsba_pkg::BIN_W-1:0]    bin,
        logic                                 eof,
        logic                                 eos,
        logic        [wsba_pkg::SCAN_W-1:0]   scan,
        logic        [wsba_pkg::SEC_W-1:0]    sec,
        logic        [wsba_pkg::NS_W-1:0]     ns);
        wsba_window_tracker_pkg::spectral_sample_t s;
        s.re     = re;
        s.im     = im;
        s.weight = weight;
        s.bin    = bin;
        s.eof    = eof;
        s.eos    = eos;
        s.scan   = scan;
        s.sec    = sec;
        s.ns     = ns;
        return s;
    endfunction

    function automatic logic signed [wsba_pkg::SAMPLE_W-1:0] rand_q15();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [wsba_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [wsba_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // returns right after the posedge at which the transaction is taken
    task automatic drive_sample(input wsba_window_tracker_pkg::spectral_sample_t it);
        @(negedge aclk);
        while (s_gaps && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample_re     <= it.re;
        s_sample_im     <= it.im;
        s_weight        <= it.weight;
        s_bin           <= it.bin;
        s_end_of_fft    <= it.eof;
        s_end_of_subint <= it.eos;
        s_scan          <= it.scan;
        s_subint_sec    <= it.sec;
        s_subint_ns     <= it.ns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drain all pending bins, then let the sample pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic directed_part();
        int i;
        // reset config: one FFT per window, all 64 bins
        drive_sample(sample_of(16'sh7FFF, 16'sh8000, 16'sh8000, 6'd0, 1'b1, 1'b0,
                               16'h0000, 31'd0, 30'd0));
        drive_sample(sample_of(16'sh8000, 16'sh7FFF, 16'sh7FFF, 6'd63, 1'b0, 1'b0,
                               16'h1234, 31'h7FFFFFFF, 30'h3FFFFFFF));
        // both flags on one sample: single close, offsets back to zero
        drive_sample(sample_of(16'sh8000, 16'sh8000, 16'sh8000, 6'd63, 1'b1, 1'b1,
                               16'hFFFF, 31'h7FFFFFFF, 30'h3FFFFFFF));
        settle();

        // zero and oversize values clamp: 1 FFT, max window, 1 bin
        write_reg(wsba_pkg::CFG_FFTS_PER_WINDOW, 30'd0);
        write_reg(wsba_pkg::CFG_WINDOW_NS, 30'h3FFFFFFF);
        write_reg(wsba_pkg::CFG_BINS_IN_USE, 30'd0);
        // ns carry into seconds, seconds wrap past 2^31
        for (i = 0; i < 4; i++)
            drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'(i), 1'b1, 1'b0,
                                   16'hABCD, 31'h7FFFFFFF, 30'd999999999));
        drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'd0, 1'b0, 1'b1,
                               16'hABCD, 31'h7FFFFFFF, 30'd999999999));
        settle();

        // clamps to 1024 FFTs, 1 ns, 64 bins; only the subint end closes
        write_reg(wsba_pkg::CFG_FFTS_PER_WINDOW, 30'd2047);
        write_reg(wsba_pkg::CFG_WINDOW_NS, 30'd0);
        write_reg(wsba_pkg::CFG_BINS_IN_USE, 30'd127);
        for (i = 0; i < 4; i++)
            drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'(i * 17), 1'b1,
                                   1'b0, 16'h0001, 31'd5, 30'd7));
        drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'd62, 1'b0, 1'b1,
                               16'h0001, 31'd5, 30'd7));
        settle();

        // ordinary close on the third FFT end, then subint end
        write_reg(wsba_pkg::CFG_FFTS_PER_WINDOW, 30'd3);
        write_reg(wsba_pkg::CFG_WINDOW_NS, 30'd999999999);
        write_reg(wsba_pkg::CFG_BINS_IN_USE, 30'd64);
        for (i = 0; i < 6; i++)
            drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'(i * 10), i[0],
                                   1'b0, 16'h00FF, 31'd100, 30'd999999000));
        drive_sample(sample_of(rand_q15(), rand_q15(), rand_q15(), 6'd1, 1'b0, 1'b1,
                               16'h00FF, 31'd100, 30'd999999000));
        settle();
    endtask

    // full-scale products pile into bin 0, back to back, then the other sign
    task automatic fullscale_part();
        int i;
        write_reg(wsba_pkg::CFG_FFTS_PER_WINDOW, 30'd2047);
        write_reg(wsba_pkg::CFG_BINS_IN_USE, 30'd2);
        s_gaps = 1'b0;
        for (i = 0; i < SAT_ITEMS; i++)
            drive_sample(sample_of(16'sh8000, 16'sh7FFF, 16'sh8000, 6'd0, 1'b0, 1'b0,
                                   16'h5A5A, 31'd12345, 30'd678));
        s_gaps = 1'b1;
        for (i = 0; i < 3; i++)
            drive_sample(sample_of(16'sh8000, 16'sh7FFF, 16'sh7FFF, 6'd0, 1'b0, 1'b0,
                                   16'h5A5A, 31'd12345, 30'd678));
        drive_sample(sample_of(16'sh1000, 16'shF000, 16'sh4000, 6'd1, 1'b1, 1'b1,
                               16'h5A5A, 31'd12345, 30'd678));
        settle();
    endtask

    task automatic random_config();
        logic [wsba_pkg::CFG_DATA_W-1:0] junk;
        logic [wsba_pkg::FFTS_W-1:0]     f;
        logic [wsba_pkg::WNS_W-1:0]      w;
        logic [wsba_pkg::NBIN_W-1:0]     b;
        case ($urandom_range(5))
            0:       f = '0;
            1:       f = wsba_pkg::FFTS_MAX;
            2:       f = wsba_pkg::FFT_CNT_MAX;
            default: f = 11'($urandom_range(1, 4));
        endcase
        case ($urandom_range(5))
            0:       w = '0;
            1:       w = wsba_pkg::WNS_MAX;
            2:       w = '1;
            default: w = 30'($urandom);
        endcase
        case ($urandom_range(5))
            0:       b = '0;
            1:       b = 7'd64;
            2:       b = 7'($urandom_range(65, 127));
            3:       b = 7'($urandom_range(1, 64));
            default: b = 7'($urandom_range(1, 8));
        endcase
        junk = 30'($urandom);
        // unused upper data bits carry noise
        write_reg(wsba_pkg::CFG_FFTS_PER_WINDOW, {junk[29:11], f});
        write_reg(wsba_pkg::CFG_WINDOW_NS, w);
        write_reg(wsba_pkg::CFG_BINS_IN_USE, {junk[22:0], b});
    endtask

    // subints of a few FFTs each, with some noise transactions mixed in
    task automatic random_traffic(input int n_items);
        wsba_window_tracker_pkg::spectral_sample_t it;
        int                            sent;
        int                            n_fft;
        int                            len;
        int                            nb;
        int                            f;
        int                            k;
        logic [wsba_pkg::SCAN_W-1:0]   scan;
        logic [wsba_pkg::SEC_W-1:0]    sec;
        logic [wsba_pkg::NS_W-1:0]     ns;
        sent = 0;
        nb   = tracker.bins_used();
        while (sent < n_items) begin
            scan  = 16'($urandom);
            sec   = ($urandom_range(7) == 0) ? 31'h7FFFFFFF : 31'($urandom);
            ns    = ($urandom_range(7) == 0) ? 30'd999999999 : 30'($urandom);
            n_fft = $urandom_range(1, 5);
            for (f = 0; f < n_fft; f++) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    it.re     = rand_q15();
                    it.im     = rand_q15();
                    it.weight = rand_q15();
                    if ($urandom_range(4) == 0) it.bin = 6'($urandom);
                    else                        it.bin = 6'($urandom_range(0, nb - 1));
                    if ($urandom_range(99) < 12) begin
                        it.eof  = 1'($urandom);
                        it.eos  = ($urandom_range(3) == 0);
                        it.scan = 16'($urandom);
                        it.sec  = 31'($urandom);
                        it.ns   = 30'($urandom);
                    end else begin
                        it.eof  = (k == len - 1);
                        it.eos  = (f == n_fft - 1) && (k == len - 1);
                        it.scan = scan;
                        it.sec  = sec;
                        it.ns   = ns;
                    end
                    drive_sample(it);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int ph;
        tracker = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        directed_part();
        fullscale_part();
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            s_gaps = (ph != 3);
            m_gaps = (ph != 3);
            random_config();
            random_traffic(PHASE_ITEMS);
            settle();
        end
        repeat (24) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_weighted_spectrum_beam_accumulator_core: PASS");
        else
            $display("tb_weighted_spectrum_beam_accumulator_core: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/wsba_pkg.sv
sv/wsba_ctrl.sv
sv/wsba_datapath.sv
sv/weighted_spectrum_beam_accumulator_core.sv
bench/wsba_window_tracker_pkg.sv
bench/tb_weighted_spectrum_beam_accumulator_core.sv
